FILE: hdl/core_wakeup_register_block_top_assert.svh
// ----------------------------------------------------------------------------
// Wake-up register block assertion macros
// Concurrent assertion wrappers, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CORE_WAKEUP_REGISTER_BLOCK_TOP_ASSERT_SVH
`define CORE_WAKEUP_REGISTER_BLOCK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CWRB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CWRB_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define CWRB_ASSERT_RST(label, prop, msg)
`define CWRB_ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: hdl/cwrb_pkg.sv
// ----------------------------------------------------------------------------
// Wake-up register block package
// Sizes, operation and result codes, register map and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwrb_pkg;

    localparam int NUM_CORES = 256;
    localparam int NWORDS    = (NUM_CORES + 63) / 64;
    localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CORE_W    = WIDX_W + 6;
    localparam int BASE_W    = 13;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 12;
    localparam int BC_W      = 4;
    localparam int WDATA_W   = 32;
    localparam int KIND_W    = 2;
    localparam int WORDIX_W  = 6;
    localparam int MASK_W    = 64;
    localparam int CFGIX_W   = 2;
    localparam int CFGVAL_W  = 32;
    localparam int EOC_W     = 31;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 136;

    localparam int LAT_W     = 16;
    localparam int GS_W      = 6;
    localparam int REGIX_W   = 1;
    localparam int REGDATA_W = 16;

    localparam logic [REGIX_W-1:0] REG_WAKE_LATENCY = 1'b0;
    localparam logic [REGIX_W-1:0] REG_GROUP_SIZE   = 1'b1;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAKE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CFG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EOC  = 2'd3;

    localparam logic [BC_W-1:0] BYTES_WORD = 4'd4;

    localparam logic [ADDR_W-1:0] ADDR_EOC        = 12'h000;
    localparam logic [ADDR_W-1:0] ADDR_WAKE       = 12'h004;
    localparam logic [ADDR_W-1:0] ADDR_TILE_FIRST = 12'h008;
    localparam logic [ADDR_W-1:0] ADDR_TILE_LAST  = 12'h104;
    localparam logic [ADDR_W-1:0] ADDR_GROUP      = 12'h108;
    localparam logic [ADDR_W-1:0] ADDR_STRIDE     = 12'h10C;
    localparam logic [ADDR_W-1:0] ADDR_OFFSET     = 12'h110;
    localparam logic [ADDR_W-1:0] ADDR_CFG0_FIRST = 12'h068;
    localparam logic [ADDR_W-1:0] ADDR_CFG0_LAST  = 12'h074;
    localparam logic [ADDR_W-1:0] ADDR_CFG1_FIRST = 12'h078;
    localparam logic [ADDR_W-1:0] ADDR_CFG1_LAST  = 12'h084;

    localparam logic [WDATA_W-1:0] WAKE_ALL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic capture;
        logic decode;
        logic mark_step;
        logic emit_pre;
        logic emit_ack;
        logic emit_wake;
    } t_dp_cmd;

    typedef struct packed {
        logic is_bus;
        logic tick_fire;
        logic mark_go;
        logic mark_done;
        logic pre_valid;
        logic out_free;
        logic wake_last;
    } t_dp_status;

endpackage

FILE: hdl/cwrb_ctrl.sv
// ----------------------------------------------------------------------------
// Wake-up register block controller
// Sequences capture, decode, mask marking and result emission for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cwrb_pkg::t_dp_status i_status,
    output cwrb_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MARK   = 3'd2;
    localparam logic [2:0] S_PRE    = 3'd3;
    localparam logic [2:0] S_ACK    = 3'd4;
    localparam logic [2:0] S_WAKE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_status.is_bus) begin
                    n_state = i_status.mark_go ? S_MARK : S_PRE;
                end else if (i_status.tick_fire) begin
                    n_state = S_WAKE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_status.mark_done) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (!i_status.pre_valid) begin
                    n_state = S_ACK;
                end else if (i_status.out_free) begin
                    o_cmd.emit_pre = 1'b1;
                    n_state        = S_ACK;
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_WAKE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_wake = 1'b1;
                    if (i_status.wake_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: hdl/cwrb_dp.sv
// ----------------------------------------------------------------------------
// Wake-up register block datapath
// Holds the control registers, the pending wake mask, the marking walker,
// the wake countdown and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwrb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cwrb_pkg::OP_W-1:0]           i_opcode,
    input  logic [cwrb_pkg::ADDR_W-1:0]         i_address,
    input  logic [cwrb_pkg::BC_W-1:0]           i_byte_count,
    input  logic [cwrb_pkg::WDATA_W-1:0]        i_write_data,
    input  logic                                i_cfg_wr,
    input  logic [cwrb_pkg::REGIX_W-1:0]        i_cfg_index,
    input  logic [cwrb_pkg::REGDATA_W-1:0]      i_cfg_data,
    input  logic                                i_out_ready,
    input  cwrb_pkg::t_dp_cmd                   i_cmd,
    output cwrb_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [cwrb_pkg::KIND_W-1:0]         o_out_kind,
    output logic [cwrb_pkg::WORDIX_W-1:0]       o_out_widx,
    output logic [cwrb_pkg::MASK_W-1:0]         o_out_mask,
    output logic [cwrb_pkg::CFGIX_W-1:0]        o_out_cfg_index,
    output logic                                o_out_cfg_bank,
    output logic [cwrb_pkg::CFGVAL_W-1:0]       o_out_cfg_value,
    output logic [cwrb_pkg::EOC_W-1:0]          o_out_eoc,
    output logic                                o_out_last
);

    localparam logic [1:0] MODE_STRIDE = 2'd0;
    localparam logic [1:0] MODE_TILE   = 2'd1;
    localparam logic [1:0] MODE_GROUP  = 2'd2;

    localparam logic [cwrb_pkg::BASE_W-1:0] CORES_B =
        cwrb_pkg::BASE_W'(cwrb_pkg::NUM_CORES);

    logic [cwrb_pkg::OP_W-1:0]      r_op;
    logic [cwrb_pkg::ADDR_W-1:0]    r_addr;
    logic [cwrb_pkg::BC_W-1:0]      r_bc;
    logic [cwrb_pkg::WDATA_W-1:0]   r_data;

    logic [cwrb_pkg::LAT_W-1:0]     r_wake_latency;
    logic [cwrb_pkg::GS_W-1:0]      r_group_size;

    logic [cwrb_pkg::MASK_W-1:0]    r_pend [cwrb_pkg::NWORDS];
    logic                           r_armed;
    logic [cwrb_pkg::LAT_W-1:0]     r_countdown;
    logic [cwrb_pkg::WDATA_W-1:0]   r_stride;
    logic [cwrb_pkg::WDATA_W-1:0]   r_offset;
    logic                           r_eoc_done;
    logic                           r_pre_valid;
    logic                           r_pre_eoc;

    logic [1:0]                     r_mode;
    logic [cwrb_pkg::BASE_W-1:0]    r_base;
    logic [5:0]                     r_t;
    logic [4:0]                     r_g;
    logic [cwrb_pkg::BASE_W-1:0]    n_base;
    logic [5:0]                     n_t;
    logic [4:0]                     n_g;

    logic [cwrb_pkg::WIDX_W-1:0]    r_widx;
    logic                           r_out_valid;

    // Decode of the captured word.
    logic       is_w4;
    logic       eoc_hit;
    logic       wake_hit;
    logic       wake_all;
    logic       tile_hit;
    logic       group_hit;
    logic       cfg0_hit;
    logic       cfg1_hit;
    logic       single_ok;
    logic       tick_fire;
    logic [9:0] tile_grp_full;
    logic [11:0] tile_base;
    logic [11:0] cfg_off;

    always_comb begin
        is_w4     = (r_op == cwrb_pkg::OP_WRITE) && (r_bc == cwrb_pkg::BYTES_WORD);
        eoc_hit   = is_w4 && (r_addr == cwrb_pkg::ADDR_EOC) && r_data[0] && !r_eoc_done;
        wake_hit  = is_w4 && (r_addr == cwrb_pkg::ADDR_WAKE);
        wake_all  = wake_hit && (r_data == cwrb_pkg::WAKE_ALL);
        tile_hit  = is_w4 && (r_addr >= cwrb_pkg::ADDR_TILE_FIRST)
                    && (r_addr <= cwrb_pkg::ADDR_TILE_LAST) && (r_addr[1:0] == 2'b00);
        group_hit = is_w4 && (r_addr == cwrb_pkg::ADDR_GROUP);
        cfg0_hit  = is_w4 && (r_addr >= cwrb_pkg::ADDR_CFG0_FIRST)
                    && (r_addr <= cwrb_pkg::ADDR_CFG0_LAST) && (r_addr[1:0] == 2'b00);
        cfg1_hit  = is_w4 && (r_addr >= cwrb_pkg::ADDR_CFG1_FIRST)
                    && (r_addr <= cwrb_pkg::ADDR_CFG1_LAST) && (r_addr[1:0] == 2'b00);
        single_ok = wake_hit && !wake_all
                    && (r_data < cwrb_pkg::WDATA_W'(cwrb_pkg::NUM_CORES));
        tick_fire = (r_op == cwrb_pkg::OP_TICK) && r_armed && (r_countdown <= 16'd1);
        tile_grp_full = r_addr[11:2] - 10'd2;
        tile_base = tile_grp_full[5:0] * {6'd0, r_group_size};
        cfg_off   = (r_addr >= cwrb_pkg::ADDR_CFG1_FIRST) ?
                    (r_addr - cwrb_pkg::ADDR_CFG1_FIRST) :
                    (r_addr - cwrb_pkg::ADDR_CFG0_FIRST);
    end

    // One step of the marking walk per cycle.
    logic                        step_mark;
    logic                        step_done;
    logic                        grp_adv;
    logic [cwrb_pkg::BASE_W-1:0] core;
    logic [cwrb_pkg::BASE_W-1:0] core_inc;
    logic [cwrb_pkg::BASE_W-1:0] base_gs;
    logic [32:0]                 stride_sum;
    logic [cwrb_pkg::WDATA_W-1:0] stride_eff;
    logic [5:0]                  gs_lim;
    logic [5:0]                  t_inc;

    always_comb begin
        core       = r_base + cwrb_pkg::BASE_W'(r_t);
        core_inc   = core + 13'd1;
        base_gs    = r_base + cwrb_pkg::BASE_W'(r_group_size);
        stride_eff = (r_stride == '0) ? 32'd1 : r_stride;
        stride_sum = 33'(r_base) + {1'b0, stride_eff};
        gs_lim     = (r_group_size > 6'd32) ? 6'd32 : r_group_size;
        t_inc      = r_t + 6'd1;
        step_mark  = 1'b0;
        step_done  = 1'b0;
        grp_adv    = 1'b0;
        n_base     = r_base;
        n_t        = r_t;
        n_g        = r_g;
        unique case (r_mode)
            MODE_STRIDE: begin
                step_mark = 1'b1;
                step_done = stride_sum >= 33'(cwrb_pkg::NUM_CORES);
                n_base    = stride_sum[cwrb_pkg::BASE_W-1:0];
            end
            MODE_TILE: begin
                step_mark = r_data[r_t[4:0]];
                step_done = (t_inc >= gs_lim) || (core_inc >= CORES_B);
                n_t       = t_inc;
            end
            MODE_GROUP: begin
                if (r_data[r_g]) begin
                    step_mark = 1'b1;
                    grp_adv   = (t_inc >= r_group_size);
                end else begin
                    grp_adv   = 1'b1;
                end
                if (grp_adv) begin
                    step_done = (r_g == 5'd31) || (base_gs >= CORES_B);
                    n_g       = r_g + 5'd1;
                    n_base    = base_gs;
                    n_t       = '0;
                end else begin
                    step_done = core_inc >= CORES_B;
                    n_t       = t_inc;
                end
            end
            default: begin
                step_done = 1'b1;
            end
        endcase
        step_mark = step_mark && (core < CORES_B);
    end

    logic                        mark_en;
    logic [cwrb_pkg::CORE_W-1:0] mark_idx;

    assign mark_en  = (i_cmd.decode && single_ok) || (i_cmd.mark_step && step_mark);
    assign mark_idx = i_cmd.decode ? r_data[cwrb_pkg::CORE_W-1:0]
                                   : core[cwrb_pkg::CORE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_addr <= i_address;
            r_bc   <= i_byte_count;
            r_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_latency <= 16'd1;
            r_group_size   <= 6'd4;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == cwrb_pkg::REG_WAKE_LATENCY) begin
                r_wake_latency <= i_cfg_data;
            end else begin
                r_group_size <= i_cfg_data[cwrb_pkg::GS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cwrb_pkg::NWORDS; i++) begin
                r_pend[i] <= '0;
            end
        end else begin
            if (mark_en) begin
                r_pend[mark_idx[cwrb_pkg::CORE_W-1:6]][mark_idx[5:0]] <= 1'b1;
            end
            if (i_cmd.emit_wake) begin
                r_pend[r_widx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_countdown <= '0;
            r_stride    <= 32'd1;
            r_offset    <= '0;
            r_eoc_done  <= 1'b0;
            r_pre_valid <= 1'b0;
            r_pre_eoc   <= 1'b0;
        end else if (i_cmd.decode) begin
            r_pre_valid <= eoc_hit || cfg0_hit || cfg1_hit;
            r_pre_eoc   <= eoc_hit;
            if (eoc_hit) begin
                r_eoc_done <= 1'b1;
            end
            if (is_w4 && (r_addr == cwrb_pkg::ADDR_STRIDE)) begin
                r_stride <= r_data;
            end
            if (is_w4 && (r_addr == cwrb_pkg::ADDR_OFFSET)) begin
                r_offset <= r_data;
            end
            if ((wake_hit || tile_hit || group_hit) && !r_armed) begin
                r_armed     <= 1'b1;
                r_countdown <= r_wake_latency;
            end
            if ((r_op == cwrb_pkg::OP_TICK) && r_armed) begin
                if (tick_fire) begin
                    r_armed     <= 1'b0;
                    r_countdown <= '0;
                end else begin
                    r_countdown <= r_countdown - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_t <= '0;
            r_g <= '0;
            if (wake_all) begin
                r_mode <= MODE_STRIDE;
                r_base <= r_offset[cwrb_pkg::BASE_W-1:0];
            end else if (tile_hit) begin
                r_mode <= MODE_TILE;
                r_base <= {1'b0, tile_base};
            end else begin
                r_mode <= MODE_GROUP;
                r_base <= '0;
            end
            r_widx <= '0;
        end else begin
            if (i_cmd.mark_step) begin
                r_base <= n_base;
                r_t    <= n_t;
                r_g    <= n_g;
            end
            if (i_cmd.emit_wake) begin
                r_widx <= r_widx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pre || i_cmd.emit_ack || i_cmd.emit_wake) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pre || i_cmd.emit_ack || i_cmd.emit_wake) begin
            o_out_kind      <= cwrb_pkg::KIND_ACK;
            o_out_widx      <= '0;
            o_out_mask      <= '0;
            o_out_cfg_index <= '0;
            o_out_cfg_bank  <= 1'b0;
            o_out_cfg_value <= '0;
            o_out_eoc       <= '0;
            o_out_last      <= 1'b0;
            if (i_cmd.emit_ack) begin
                o_out_last <= 1'b1;
            end else if (i_cmd.emit_wake) begin
                o_out_kind <= cwrb_pkg::KIND_WAKE;
                o_out_widx <= cwrb_pkg::WORDIX_W'(r_widx);
                o_out_mask <= r_pend[r_widx];
                o_out_last <= (r_widx == cwrb_pkg::WIDX_W'(cwrb_pkg::NWORDS - 1));
            end else if (r_pre_eoc) begin
                o_out_kind <= cwrb_pkg::KIND_EOC;
                o_out_eoc  <= r_data[31:1];
            end else begin
                o_out_kind      <= cwrb_pkg::KIND_CFG;
                o_out_cfg_index <= cfg_off[3:2];
                o_out_cfg_bank  <= (r_addr >= cwrb_pkg::ADDR_CFG1_FIRST);
                o_out_cfg_value <= r_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.is_bus    = (r_op == cwrb_pkg::OP_WRITE) || (r_op == cwrb_pkg::OP_READ);
        o_status.tick_fire = tick_fire;
        o_status.mark_go   = (wake_all && (r_offset < cwrb_pkg::WDATA_W'(cwrb_pkg::NUM_CORES)))
                             || ((tile_hit || group_hit) && (r_group_size != '0));
        o_status.mark_done = step_done;
        o_status.pre_valid = r_pre_valid;
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_status.wake_last = (r_widx == cwrb_pkg::WIDX_W'(cwrb_pkg::NWORDS - 1));
    end

endmodule

FILE: hdl/core_wakeup_register_block_top.sv
// ----------------------------------------------------------------------------
// Multicore wake-up register block
// Bus writes, bus reads and clock ticks arrive as words on the slave stream;
// results leave as words on the master stream, and two settings (wake latency
// and group size) are to be written through a separate write channel only
// while idle; the block itself does not enforce it. One word is handled at
// a time: a bus access passes through capture and decode, a marking walk
// when it marks by stride, tile or group mask, any setting or EOC result
// and the acknowledge. A tick passes through capture and decode, and the
// expiring tick emits the pending mask one 64-core word at a time. A new
// word is accepted while the last result still waits in the output
// register. Reset clears the pending mask, the countdown and the
// end-of-computation flag, and restores the settings. While the receiver
// stalls, the block holds its result and waits in the emitting step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "core_wakeup_register_block_top_assert.svh"

module core_wakeup_register_block_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // address [11:0], byte_count [15:12], write_data [47:16]
    input  logic [cwrb_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // opcode [1:0]
    input  logic [cwrb_pkg::OP_W-1:0]            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // word_index [5:0], wake_mask [69:6], cfg_index [71:70], cfg_bank [72],
    // cfg_value [104:73], eoc_value [135:105]
    output logic [cwrb_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // kind [1:0]
    output logic [cwrb_pkg::KIND_W-1:0]          o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cwrb_pkg::REGIX_W-1:0]         i_cfg_index,
    input  logic [cwrb_pkg::REGDATA_W-1:0]       i_cfg_data
);

    cwrb_pkg::t_dp_cmd    cmd;
    cwrb_pkg::t_dp_status status;

    logic [cwrb_pkg::WORDIX_W-1:0] out_widx;
    logic [cwrb_pkg::MASK_W-1:0]   out_mask;
    logic [cwrb_pkg::CFGIX_W-1:0]  out_cfg_index;
    logic                          out_cfg_bank;
    logic [cwrb_pkg::CFGVAL_W-1:0] out_cfg_value;
    logic [cwrb_pkg::EOC_W-1:0]    out_eoc;

    assign o_cfg_ready = 1'b1;

    cwrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cwrb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_s_axis_tuser),
        .i_address       (i_s_axis_tdata[11:0]),
        .i_byte_count    (i_s_axis_tdata[15:12]),
        .i_write_data    (i_s_axis_tdata[47:16]),
        .i_cfg_wr        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_m_axis_tvalid),
        .o_out_kind      (o_m_axis_tuser),
        .o_out_widx      (out_widx),
        .o_out_mask      (out_mask),
        .o_out_cfg_index (out_cfg_index),
        .o_out_cfg_bank  (out_cfg_bank),
        .o_out_cfg_value (out_cfg_value),
        .o_out_eoc       (out_eoc),
        .o_out_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_eoc, out_cfg_value, out_cfg_bank, out_cfg_index,
                             out_mask, out_widx};

    `CWRB_ASSERT_RST(a_one_word_at_a_time, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "word accepted while busy")
    `CWRB_ASSERT_RST(a_ack_is_last, o_m_axis_tvalid && (o_m_axis_tuser == cwrb_pkg::KIND_ACK) |-> o_m_axis_tlast, "acknowledge without last")
    `CWRB_ASSERT_NEVER(a_pre_not_last, o_m_axis_tvalid && o_m_axis_tlast && ((o_m_axis_tuser == cwrb_pkg::KIND_CFG) || (o_m_axis_tuser == cwrb_pkg::KIND_EOC)), "setting result marked last")

endmodule

FILE: tb/core_wakeup_register_block_top_tb.sv
// ----------------------------------------------------------------------------
// Wake-up register block testbench
// Drives bus writes, bus reads and clock ticks into the slave stream and
// checks every result word on the master stream against a cycle-free
// predictor of the register map, the pending wake mask and the countdown.
// Directed tests cover the register map, latency and group size extremes;
// random traffic follows under several settings, with idling on both sides in all but the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module core_wakeup_register_block_top_tb;

    import cwrb_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [WORDIX_W-1:0] word_idx;
        logic [MASK_W-1:0]   mask;
        logic [CFGIX_W-1:0]  cfg_idx;
        logic                cfg_bank;
        logic [CFGVAL_W-1:0] cfg_val;
        logic [EOC_W-1:0]    eoc_val;
        logic                last;
    } wake_reg_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [OP_W-1:0]       i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [KIND_W-1:0]     o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [REGIX_W-1:0]    i_cfg_index;
    logic [REGDATA_W-1:0]  i_cfg_data;

    // Predictor state.
    logic [LAT_W-1:0]      wake_latency;
    logic [GS_W-1:0]       group_size;
    logic [MASK_W-1:0]     pending_mask [NWORDS];
    logic                  wake_armed;
    logic [LAT_W-1:0]      countdown;
    logic [WDATA_W-1:0]    stride_reg;
    logic [WDATA_W-1:0]    start_offset;
    logic                  eoc_done;

    wake_reg_result_t      awaited_results [$];
    int                    mismatches;
    bit                    tx_idle_en;
    bit                    rx_idle_en;
    int                    rx_stall_left;

    core_wakeup_register_block_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void push_result(logic [KIND_W-1:0] kind, int widx,
                                        logic [MASK_W-1:0] mask, int cidx, logic bank,
                                        logic [CFGVAL_W-1:0] cval, logic [EOC_W-1:0] eoc,
                                        logic last);
        wake_reg_result_t r;
        r.kind     = kind;
        r.word_idx = WORDIX_W'(widx);
        r.mask     = mask;
        r.cfg_idx  = CFGIX_W'(cidx);
        r.cfg_bank = bank;
        r.cfg_val  = cval;
        r.eoc_val  = eoc;
        r.last     = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void mark_core(longint unsigned core);
        if (core < NUM_CORES)
            pending_mask[core >> 6][core % 64] = 1'b1;
    endfunction

    function automatic void arm_countdown();
        if (!wake_armed) begin
            wake_armed = 1'b1;
            countdown  = wake_latency;
        end
    endfunction

    function automatic void predict_response(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                             logic [BC_W-1:0] nbytes,
                                             logic [WDATA_W-1:0] wdata);
        longint unsigned core;
        longint unsigned step;
        longint unsigned grp;
        longint unsigned gsz;
        gsz = longint'(group_size);
        if (op == OP_WRITE || op == OP_READ) begin
            if (op == OP_WRITE && nbytes == BYTES_WORD) begin
                if (addr == ADDR_EOC && wdata[0] && !eoc_done) begin
                    eoc_done = 1'b1;
                    push_result(KIND_EOC, 0, '0, 0, 1'b0, '0, wdata[31:1], 1'b0);
                end
                if (addr == ADDR_WAKE) begin
                    if (wdata == WAKE_ALL) begin
                        step = (stride_reg == 0) ? 1 : longint'(stride_reg);
                        for (core = start_offset; core < NUM_CORES; core += step)
                            mark_core(core);
                    end else begin
                        mark_core(longint'(wdata));
                    end
                    arm_countdown();
                end
                if (addr >= ADDR_TILE_FIRST && addr <= ADDR_TILE_LAST && addr[1:0] == 2'b00)
                begin
                    grp = longint'((addr - ADDR_TILE_FIRST) >> 2);
                    for (longint unsigned t = 0; t < gsz; t++)
                        if (t < 32 && wdata[t])
                            mark_core(grp * gsz + t);
                    arm_countdown();
                end
                if (addr == ADDR_GROUP) begin
                    for (grp = 0; grp < 32; grp++)
                        if (wdata[grp])
                            for (longint unsigned t = 0; t < gsz; t++)
                                mark_core(grp * gsz + t);
                    arm_countdown();
                end
                if (addr == ADDR_STRIDE)
                    stride_reg = wdata;
                if (addr == ADDR_OFFSET)
                    start_offset = wdata;
                if (addr >= ADDR_CFG0_FIRST && addr <= ADDR_CFG0_LAST && addr[1:0] == 2'b00)
                    push_result(KIND_CFG, 0, '0, int'((addr - ADDR_CFG0_FIRST) >> 2), 1'b0,
                                wdata, '0, 1'b0);
                if (addr >= ADDR_CFG1_FIRST && addr <= ADDR_CFG1_LAST && addr[1:0] == 2'b00)
                    push_result(KIND_CFG, 0, '0, int'((addr - ADDR_CFG1_FIRST) >> 2), 1'b1,
                                wdata, '0, 1'b0);
            end
            push_result(KIND_ACK, 0, '0, 0, 1'b0, '0, '0, 1'b1);
        end else if (op == OP_TICK && wake_armed) begin
            if (countdown > 1) begin
                countdown = countdown - 1'b1;
            end else begin
                countdown  = '0;
                wake_armed = 1'b0;
                for (int w = 0; w < NWORDS; w++) begin
                    push_result(KIND_WAKE, w, pending_mask[w], 0, 1'b0, '0, '0,
                                w == NWORDS - 1);
                    pending_mask[w] = '0;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                   input logic [MASK_W-1:0] want);
        if (mismatches < 200)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        wake_reg_result_t got;
        wake_reg_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind     = o_m_axis_tuser;
            got.word_idx = o_m_axis_tdata[5:0];
            got.mask     = o_m_axis_tdata[69:6];
            got.cfg_idx  = o_m_axis_tdata[71:70];
            got.cfg_bank = o_m_axis_tdata[72];
            got.cfg_val  = o_m_axis_tdata[104:73];
            got.eoc_val  = o_m_axis_tdata[135:105];
            got.last     = o_m_axis_tlast;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected word, kind", got.kind, '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", got.kind, want.kind);
                if (got.word_idx !== want.word_idx)
                    report_mismatch("word_index", got.word_idx, want.word_idx);
                if (got.mask !== want.mask)
                    report_mismatch("wake_mask", got.mask, want.mask);
                if (got.cfg_idx !== want.cfg_idx)
                    report_mismatch("cfg_index", got.cfg_idx, want.cfg_idx);
                if (got.cfg_bank !== want.cfg_bank)
                    report_mismatch("cfg_bank", got.cfg_bank, want.cfg_bank);
                if (got.cfg_val !== want.cfg_val)
                    report_mismatch("cfg_value", got.cfg_val, want.cfg_val);
                if (got.eoc_val !== want.eoc_val)
                    report_mismatch("eoc_value", got.eoc_val, want.eoc_val);
                if (got.last !== want.last)
                    report_mismatch("tlast", got.last, want.last);
            end
        end
    end

    // The receiver stalls in bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; each is entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [BC_W-1:0] nbytes, input logic [WDATA_W-1:0] wdata);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {wdata, nbytes, addr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_response(op, addr, nbytes, wdata);
        @(negedge i_clk);
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_word(input logic [ADDR_W-1:0] addr, input logic [WDATA_W-1:0] wdata);
        send_item(OP_WRITE, addr, BYTES_WORD, wdata);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, ADDR_W'($urandom), BC_W'($urandom), $urandom);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_setting(input logic [REGIX_W-1:0] idx, input logic [REGDATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_WAKE_LATENCY)
            wake_latency = val;
        else
            group_size = val[GS_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic begin_phase(input logic [REGDATA_W-1:0] lat, input logic [REGDATA_W-1:0] gsz);
        drain_results();
        write_setting(REG_WAKE_LATENCY, lat);
        write_setting(REG_GROUP_SIZE, gsz);
    endtask

    task automatic send_random_item();
        int pick;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [BC_W-1:0]    nbytes;
        logic [WDATA_W-1:0] wdata;
        pick   = $urandom_range(0, 99);
        op     = OP_WRITE;
        nbytes = BYTES_WORD;
        wdata  = $urandom;
        addr   = ADDR_EOC;
        if (pick < 30) begin
            op     = OP_TICK;
            addr   = ADDR_W'($urandom);
            nbytes = BC_W'($urandom);
        end else if (pick < 44) begin
            addr  = ADDR_WAKE;
            wdata = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, NUM_CORES + 40);
        end else if (pick < 52) begin
            addr  = ADDR_WAKE;
            wdata = WAKE_ALL;
        end else if (pick < 62) begin
            addr = ADDR_TILE_FIRST + ADDR_W'(4 * $urandom_range(0, 63));
        end else if (pick < 66) begin
            addr = ADDR_GROUP;
        end else if (pick < 71) begin
            addr  = ADDR_STRIDE;
            wdata = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 9);
        end else if (pick < 76) begin
            addr  = ADDR_OFFSET;
            wdata = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, NUM_CORES + 20);
        end else if (pick < 82) begin
            addr = ($urandom_range(0, 1) ? ADDR_CFG0_FIRST : ADDR_CFG1_FIRST)
                   + ADDR_W'(4 * $urandom_range(0, 3));
        end else if (pick < 85) begin
            addr = ADDR_EOC;
        end else if (pick < 90) begin
            op     = OP_READ;
            addr   = ADDR_W'($urandom);
            nbytes = BC_W'($urandom);
        end else if (pick < 96) begin
            addr   = ADDR_W'($urandom);
            nbytes = BC_W'($urandom);
        end else begin
            op     = OP_NONE;
            addr   = ADDR_W'($urandom);
            nbytes = BC_W'($urandom);
        end
        send_item(op, addr, nbytes, wdata);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_map();
        send_item(OP_READ, ADDR_EOC, BYTES_WORD, '0);
        write_word(ADDR_EOC, 32'hFFFF_FFFF);
        write_word(ADDR_EOC, 32'h0000_0003);
        write_word(ADDR_EOC, 32'h0000_0002);
        send_item(OP_WRITE, ADDR_WAKE, 4'd2, 32'd5);
        send_item(OP_WRITE, ADDR_STRIDE, 4'd8, 32'd3);
        write_word(12'h200, 32'hA5A5_5A5A);
        write_word(ADDR_WAKE, 32'd0);
        write_word(ADDR_WAKE, 32'd255);
        write_word(ADDR_WAKE, 32'd256);
        send_tick();
        write_word(ADDR_WAKE, 32'd300);
        send_tick();
        write_word(ADDR_STRIDE, 32'd0);
        write_word(ADDR_OFFSET, 32'd3);
        write_word(ADDR_WAKE, WAKE_ALL);
        send_tick();
        write_word(ADDR_STRIDE, 32'hFFFF_FFFF);
        write_word(ADDR_OFFSET, 32'd0);
        write_word(ADDR_WAKE, WAKE_ALL);
        write_word(ADDR_TILE_FIRST, 32'h0000_000F);
        write_word(ADDR_TILE_LAST, 32'hFFFF_FFFF);
        write_word(ADDR_CFG0_FIRST, 32'h1234_5678);
        write_word(ADDR_CFG1_LAST, 32'h8765_4321);
        write_word(ADDR_CFG0_FIRST + 12'd2, 32'hFFFF_FFFF);
        write_word(ADDR_GROUP, 32'h8000_0001);
        send_tick();
        send_item(OP_NONE, 12'hFFF, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_READ, 12'hFFF, 4'hF, 32'hFFFF_FFFF);
    endtask

    task automatic test_wake_latency();
        begin_phase(16'd3, 16'd4);
        write_word(ADDR_WAKE, 32'd5);
        send_tick();
        write_word(ADDR_WAKE, 32'd6);
        send_tick();
        send_tick();
        begin_phase(16'd0, 16'd4);
        write_word(ADDR_WAKE, 32'd200);
        send_tick();
        begin_phase(16'hFFFF, 16'd4);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_word(ADDR_WAKE, 32'd17);
        repeat (65535) send_tick();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_group_sizes();
        begin_phase(16'd1, 16'd0);
        write_word(ADDR_TILE_FIRST, 32'hFFFF_FFFF);
        write_word(ADDR_GROUP, 32'hFFFF_FFFF);
        send_tick();
        begin_phase(16'd1, 16'd1);
        write_word(ADDR_TILE_LAST, 32'h0000_0001);
        write_word(ADDR_GROUP, 32'h8000_0001);
        send_tick();
        begin_phase(16'd1, 16'd32);
        write_word(ADDR_TILE_FIRST + 12'd4, 32'hFFFF_FFFF);
        write_word(ADDR_GROUP, 32'h0000_0100);
        send_tick();
        begin_phase(16'd2, 16'hFFFF);
        write_word(ADDR_TILE_FIRST, 32'hFFFF_FFFF);
        write_word(ADDR_TILE_FIRST + 12'd8, 32'h8000_0001);
        send_tick();
        send_tick();
    endtask

    task automatic test_random_traffic(input logic [REGDATA_W-1:0] lat,
                                       input logic [REGDATA_W-1:0] gsz, input int count,
                                       input bit idling);
        begin_phase(lat, gsz);
        tx_idle_en = idling;
        rx_idle_en = idling;
        repeat (count) send_random_item();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_READ;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_WAKE_LATENCY;
        i_cfg_data      = '0;
        rx_stall_left   = 0;
        mismatches      = 0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        wake_latency    = 16'd1;
        group_size      = 6'd4;
        wake_armed      = 1'b0;
        countdown       = '0;
        stride_reg      = 32'd1;
        start_offset    = '0;
        eoc_done        = 1'b0;
        for (int w = 0; w < NWORDS; w++)
            pending_mask[w] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_map();
        test_wake_latency();
        test_group_sizes();
        test_random_traffic(16'd2, 16'd4, 45, 1'b1);
        test_random_traffic(16'd1, 16'd32, 45, 1'b1);
        test_random_traffic(16'd5, 16'd7, 45, 1'b1);
        test_random_traffic(16'd0, 16'd1, 45, 1'b1);
        test_random_traffic(16'd3, 16'd0, 40, 1'b1);
        test_random_traffic(16'd1, 16'd4, 40, 1'b0);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
